/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define ASSERT_SAME(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/mfir_pkg.sv */
package mfir_pkg;

  // Filter shape
  localparam int HISTORY_DEPTH = 5;
  localparam int CHANNEL_COUNT = 4;
  localparam int IO_CHANNELS   = 4;
  localparam int COEF_COUNT    = 6;

  // Taps that carry a weight, and the history they need
  localparam int USED_TAPS = (HISTORY_DEPTH + 1 < COEF_COUNT) ? HISTORY_DEPTH + 1 : COEF_COUNT;
  localparam int HIST_USED = USED_TAPS - 1;

  // Datapath widths
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + $clog2(COEF_COUNT);
  localparam int FRAC_BITS = 15;
  localparam int RND_W     = ACC_W + 1;
  localparam int Q_W       = RND_W - FRAC_BITS;

  // Configuration port
  localparam int ADDR_W    = $clog2(COEF_COUNT * 4);
  localparam int DATA_W    = 32;
  localparam int IDX_W     = ADDR_W - 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Unity-gain symmetric low-pass weights
  localparam coef_t COEF_RESET [COEF_COUNT] = '{
    16'sd333, 16'sd3857, 16'sd12194, 16'sd12194, 16'sd3857, 16'sd333
  };

  // Per-stage load strobes sent to every lane
  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } lane_ctrl_t;

endpackage

/* rtl/multichannel_fir_filter.sv */
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_sample_ch0..3, signed 16 bit
// out_      output     out_valid/out_stall  out_filtered_ch0..3, signed 16 bit
// cfg       APB write  psel/penable/pready  coef_0..5 at byte address 4*i
//
// Each accepted transaction passes through the product, adder and output stages;
// one transaction is taken per cycle while in_stall is low.
// Reset (rst_n low, synchronous) clears the delay lines and loads the default
// weights. A stalled result holds in the output register while the product
// and adder stages keep filling; in_stall rises only once all three are full.
`include "assert_macros.svh"

module multichannel_fir_filter
  import mfir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sample_t           in_sample_ch0,
  input  sample_t           in_sample_ch1,
  input  sample_t           in_sample_ch2,
  input  sample_t           in_sample_ch3,
  output logic              out_valid,
  input  logic              out_stall,
  output sample_t           out_filtered_ch0,
  output sample_t           out_filtered_ch1,
  output sample_t           out_filtered_ch2,
  output sample_t           out_filtered_ch3,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  coef_t      coef_r [COEF_COUNT];
  logic [IDX_W-1:0] cfg_idx;
  logic       cfg_wr;

  sample_t    in_arr  [IO_CHANNELS];
  acc_t       acc     [CHANNEL_COUNT];
  sample_t    y       [IO_CHANNELS];

  logic       s1_v_r, s2_v_r, out_v_r;
  logic       s1_ready, s2_ready, out_ready;
  logic       in_accept;
  lane_ctrl_t ctrl;

  // Register file
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else if (cfg_wr && (32'(cfg_idx) < COEF_COUNT)) begin
      coef_r[cfg_idx[$clog2(COEF_COUNT)-1:0]] <= pwdata[COEF_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (32'(cfg_idx) < COEF_COUNT) begin
      prdata = DATA_W'(coef_r[cfg_idx[$clog2(COEF_COUNT)-1:0]]);
    end
  end

  // Pipeline flow: a stage loads when empty or when its successor moves on
  assign out_ready = !out_v_r || !out_stall;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  // Stage strobes, s1_load first
  assign ctrl = {in_accept, s1_v_r && s2_ready};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (out_ready) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // One filter lane per active channel
  assign in_arr[0] = in_sample_ch0;
  assign in_arr[1] = in_sample_ch1;
  assign in_arr[2] = in_sample_ch2;
  assign in_arr[3] = in_sample_ch3;

  for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_lane
    mfir_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .sample_i (in_arr[c]),
      .coef_i   (coef_r),
      .acc_o    (acc[c])
    );
  end

  // Round, clamp and register all channels together
  mfir_merge u_merge (
    .clk   (clk),
    .load  (s2_v_r && out_ready),
    .acc_i (acc),
    .y_o   (y)
  );

  assign out_valid        = out_v_r;
  assign out_filtered_ch0 = y[0];
  assign out_filtered_ch1 = y[1];
  assign out_filtered_ch2 = y[2];
  assign out_filtered_ch3 = y[3];

  `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_accept, s1_v_r)
  `ASSERT_NEXT(a_s2_holds, clk, rst_n, s2_v_r && !out_ready, s2_v_r)
  `ASSERT_SAME(a_full_pipe_stalls, clk, rst_n, s1_v_r && s2_v_r && out_v_r && out_stall, in_stall)

endmodule

/* rtl/mfir_lane.sv */
module mfir_lane
  import mfir_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctrl_t ctrl,
  input  sample_t    sample_i,
  input  coef_t      coef_i [COEF_COUNT],
  output acc_t       acc_o
);

  sample_t hist_r   [HIST_USED];
  sample_t tap      [USED_TAPS];
  prod_t   prod_nxt [USED_TAPS];
  prod_t   prod_r   [USED_TAPS];
  acc_t    acc_nxt;
  acc_t    acc_r;

  // Line up the newest sample with the stored history
  always_comb begin
    tap[0] = sample_i;
    for (int k = 1; k < USED_TAPS; k++) begin
      tap[k] = hist_r[k-1];
    end
  end

  // Form one product per weighted tap
  always_comb begin
    for (int k = 0; k < USED_TAPS; k++) begin
      prod_nxt[k] = PROD_W'(tap[k]) * PROD_W'(coef_i[k]);
    end
  end

  // Advance the delay line on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HIST_USED; k++) begin
        hist_r[k] <= '0;
      end
    end else if (ctrl.s1_load) begin
      hist_r[0] <= sample_i;
      for (int k = 1; k < HIST_USED; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

  // Hold products for the adder stage
  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      prod_r <= prod_nxt;
    end
  end

  // Sum the products exactly
  always_comb begin
    acc_nxt = '0;
    for (int k = 0; k < USED_TAPS; k++) begin
      acc_nxt = acc_nxt + ACC_W'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s2_load) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_o = acc_r;

endmodule

/* rtl/mfir_merge.sv */
module mfir_merge
  import mfir_pkg::*;
(
  input  logic    clk,
  input  logic    load,
  input  acc_t    acc_i [CHANNEL_COUNT],
  output sample_t y_o   [IO_CHANNELS]
);

  localparam logic signed [RND_W-1:0] ROUND_BIAS = RND_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [Q_W-1:0]   SAT_MAX    = Q_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [Q_W-1:0]   SAT_MIN    = -Q_W'(2 ** (SAMPLE_W - 1));

  logic signed [RND_W-1:0] rnd [CHANNEL_COUNT];
  logic signed [Q_W-1:0]   q   [CHANNEL_COUNT];
  sample_t                 y_nxt [IO_CHANNELS];
  sample_t                 y_r   [IO_CHANNELS];

  // Round half up, drop the fraction and clamp; idle channels read zero
  always_comb begin
    for (int c = 0; c < IO_CHANNELS; c++) begin
      y_nxt[c] = '0;
    end
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      rnd[c] = RND_W'(acc_i[c]) + ROUND_BIAS;
      q[c]   = Q_W'(rnd[c] >>> FRAC_BITS);
      if (q[c] > SAT_MAX) begin
        y_nxt[c] = SAT_MAX[SAMPLE_W-1:0];
      end else if (q[c] < SAT_MIN) begin
        y_nxt[c] = SAT_MIN[SAMPLE_W-1:0];
      end else begin
        y_nxt[c] = q[c][SAMPLE_W-1:0];
      end
    end
  end

  // Hold the result until the next load
  always_ff @(posedge clk) begin
    if (load) begin
      y_r <= y_nxt;
    end
  end

  assign y_o = y_r;

endmodule

/* test/tb_top.sv */
module tb_top;
  import mfir_pkg::*;

  localparam int     IDLE_LIMIT     = 2000;
  localparam int     RANDOM_PHASES  = 8;
  localparam int     PHASE_FRAMES   = 72;
  localparam int     MAX_REPORTS    = 10;
  localparam longint ROUND_HALF     = 64'sd1 <<< (FRAC_BITS - 1);
  localparam longint OUT_MAX        = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint OUT_MIN        = -(64'sd1 <<< (SAMPLE_W - 1));

  // Register map: six weights, then two unused slots in the address space
  typedef enum int {
    REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4, REG_COEF_5,
    REG_SPARE_6, REG_SPARE_7
  } cfg_reg_e;

  typedef enum logic [1:0] {ROW_ITEM, ROW_ITEM_CHECKED, ROW_COEFS} row_kind_e;

  // One sample or filtered value per channel; element 0 is channel zero
  typedef logic [IO_CHANNELS-1:0][SAMPLE_W-1:0] frame_t;
  typedef logic [COEF_COUNT-1:0][COEF_W-1:0]    coef_set_t;

  typedef struct packed {
    row_kind_e kind;
    frame_t    data;
    frame_t    known;
    coef_set_t coefs;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  sample_t           in_sample_ch0 = '0;
  sample_t           in_sample_ch1 = '0;
  sample_t           in_sample_ch2 = '0;
  sample_t           in_sample_ch3 = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  sample_t           out_filtered_ch0;
  sample_t           out_filtered_ch1;
  sample_t           out_filtered_ch2;
  sample_t           out_filtered_ch3;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Filter state mirrored by the predictor
  coef_t     fir_coef [COEF_COUNT];
  sample_t   fir_hist [CHANNEL_COUNT][HISTORY_DEPTH];
  frame_t    filtered_q [$];
  stim_row_t directed_rows [$];

  int gap_mode = 1;
  int stall_mode = 1;
  int stall_hold = 0;
  int idle_cycles = 0;
  int err_count = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int coef_writes = 0;
  int coef_settings = 0;
  frame_t got;
  frame_t want;

  multichannel_fir_filter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_ch0    (in_sample_ch0),
    .in_sample_ch1    (in_sample_ch1),
    .in_sample_ch2    (in_sample_ch2),
    .in_sample_ch3    (in_sample_ch3),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered_ch0 (out_filtered_ch0),
    .out_filtered_ch1 (out_filtered_ch1),
    .out_filtered_ch2 (out_filtered_ch2),
    .out_filtered_ch3 (out_filtered_ch3),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic frame_t mk_frame(input int c0, input int c1, input int c2, input int c3);
    frame_t f;
    f[0] = c0[SAMPLE_W-1:0];
    f[1] = c1[SAMPLE_W-1:0];
    f[2] = c2[SAMPLE_W-1:0];
    f[3] = c3[SAMPLE_W-1:0];
    return f;
  endfunction

  function automatic coef_set_t mk_coefs(input int w0, input int w1, input int w2,
                                         input int w3, input int w4, input int w5);
    coef_set_t s;
    s[0] = w0[COEF_W-1:0];
    s[1] = w1[COEF_W-1:0];
    s[2] = w2[COEF_W-1:0];
    s[3] = w3[COEF_W-1:0];
    s[4] = w4[COEF_W-1:0];
    s[5] = w5[COEF_W-1:0];
    return s;
  endfunction

  function automatic void add_row(input row_kind_e kind, input frame_t data,
                                  input frame_t known, input coef_set_t coefs);
    stim_row_t r;
    r.kind  = kind;
    r.data  = data;
    r.known = known;
    r.coefs = coefs;
    directed_rows.push_back(r);
  endfunction

  // Weighted sum per channel, round half up, saturate; then shift the delay line
  function automatic frame_t fir_predict(input frame_t x);
    frame_t y;
    longint acc;
    longint q;
    y = '0;
    for (int c = 0; c < IO_CHANNELS; c++) begin
      if (c < CHANNEL_COUNT) begin
        acc = longint'(fir_coef[0]) * longint'($signed(x[c]));
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
          if (k + 1 < COEF_COUNT) begin
            acc += longint'(fir_coef[k+1]) * longint'(fir_hist[c][k]);
          end
        end
        for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
          fir_hist[c][k] = fir_hist[c][k-1];
        end
        fir_hist[c][0] = x[c];
        q = (acc + ROUND_HALF) >>> FRAC_BITS;
        if (q > OUT_MAX) q = OUT_MAX;
        if (q < OUT_MIN) q = OUT_MIN;
        y[c] = q[SAMPLE_W-1:0];
      end
    end
    return y;
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // Mostly short gaps, the odd long one when the mode allows it
  function automatic int idle_len(input int mode);
    if (mode == 0) return 0;
    if (mode == 2 && $urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] prev);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1: return prev;
      2, 3: return SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
      4: begin
        case ($urandom_range(0, 3))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0001;
          default: return 16'hffff;
        endcase
      end
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  // One APB write; psel stays high so writes can run back to back
  task automatic cfg_write(input cfg_reg_e idx, input coef_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= {{(DATA_W - COEF_W){val[COEF_W-1]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (int'(idx) < COEF_COUNT) fir_coef[int'(idx)] = val;
    coef_writes++;
  endtask

  // Drain the pipe, then load all six weights and poke an unused slot
  task automatic program_coefs(input coef_set_t w);
    logic [31:0] r;
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    for (int k = 0; k < COEF_COUNT; k++) begin
      cfg_write(cfg_reg_e'(int'(REG_COEF_0) + k), w[k]);
    end
    r = $urandom;
    cfg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, r[COEF_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    coef_settings++;
  endtask

  // Offer one frame, hold it until taken, then idle for a random gap
  task automatic send_frame(input frame_t smp, input logic use_known, input frame_t known);
    frame_t pred;
    int gap;
    in_valid      <= 1'b1;
    in_sample_ch0 <= smp[0];
    in_sample_ch1 <= smp[1];
    in_sample_ch2 <= smp[2];
    in_sample_ch3 <= smp[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = fir_predict(smp);
    filtered_q.push_back(use_known ? known : pred);
    frames_sent++;
    gap = idle_len(gap_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= (stall_mode != 0) && ($urandom_range(0, 2) == 0);
      stall_hold <= idle_len(stall_mode);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = {out_filtered_ch3, out_filtered_ch2, out_filtered_ch1, out_filtered_ch0};
      results_seen++;
      if (filtered_q.size() == 0) begin
        note_error($sformatf("result with nothing expected: %h", got));
      end else begin
        want = filtered_q.pop_front();
        for (int c = 0; c < IO_CHANNELS; c++) begin
          if (got[c] !== want[c]) begin
            note_error($sformatf("result %0d filtered_ch%0d: expected %0d, got %0d",
                                 results_seen, c, $signed(want[c]), $signed(got[c])));
          end
        end
      end
    end
  end

  // Abort when no transaction of any kind moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    coef_set_t w;
    frame_t smp;
    logic [31:0] r;
    frame_t none;
    none = '0;
    for (int k = 0; k < COEF_COUNT; k++) fir_coef[k] = COEF_RESET[k];
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) fir_hist[c][k] = '0;
    end

    // Directed part: zeros after reset, DC at full scale, saturation, rounding
    add_row(ROW_ITEM_CHECKED, mk_frame(0, 0, 0, 0), mk_frame(0, 0, 0, 0), '0);
    repeat (5) add_row(ROW_ITEM, mk_frame(32767, -32768, 1, -1), none, '0);
    add_row(ROW_ITEM_CHECKED, mk_frame(32767, -32768, 1, -1),
            mk_frame(32767, -32768, 1, -1), '0);
    add_row(ROW_ITEM, mk_frame(-32768, 32767, -1, 1), none, '0);
    add_row(ROW_ITEM, mk_frame(12345, -12345, 255, -256), none, '0);
    repeat (5) add_row(ROW_ITEM, mk_frame(32767, -32768, 0, 0), none, '0);
    add_row(ROW_ITEM_CHECKED, mk_frame(32767, -32768, 0, 0),
            mk_frame(32767, -32768, 0, 0), '0);
    add_row(ROW_COEFS, none, none,
            mk_coefs(32767, 32767, 32767, 32767, 32767, 32767));
    add_row(ROW_ITEM_CHECKED, mk_frame(32767, -32768, 0, 0),
            mk_frame(32767, -32768, 0, 0), '0);
    add_row(ROW_COEFS, none, none,
            mk_coefs(-32768, -32768, -32768, -32768, -32768, -32768));
    add_row(ROW_ITEM_CHECKED, mk_frame(32767, -32768, 0, 0),
            mk_frame(-32768, 32767, 0, 0), '0);
    add_row(ROW_COEFS, none, none, mk_coefs(-32768, 0, 0, 0, 0, 0));
    add_row(ROW_ITEM_CHECKED, mk_frame(-32768, 32767, 0, 1),
            mk_frame(32767, -32767, 0, -1), '0);
    add_row(ROW_COEFS, none, none, mk_coefs(16384, 0, 0, 0, 0, 0));
    add_row(ROW_ITEM_CHECKED, mk_frame(1, -1, 3, -3), mk_frame(1, 0, 2, -1), '0);
    add_row(ROW_COEFS, none, none, mk_coefs(0, 0, 0, 0, 0, -32768));
    repeat (5) add_row(ROW_ITEM, mk_frame(100, -100, 32767, -32768), none, '0);
    add_row(ROW_ITEM_CHECKED, mk_frame(0, 0, 0, 0),
            mk_frame(-100, 100, -32767, 32767), '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_COEFS) begin
        program_coefs(row.coefs);
      end else begin
        send_frame(row.data, row.kind == ROW_ITEM_CHECKED, row.known);
      end
    end

    // Random phases, each under its own weights and idling pattern
    smp = '0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int k = 0; k < COEF_COUNT; k++) begin
        r = $urandom;
        case (phase % 4)
          0: w[k] = COEF_RESET[k];
          1: w[k] = r[COEF_W-1:0];
          2: w[k] = COEF_W'($urandom_range(0, 8191)) - COEF_W'(4096);
          default: begin
            case ($urandom_range(0, 3))
              0: w[k] = 16'h7fff;
              1: w[k] = 16'h8000;
              2: w[k] = '0;
              default: w[k] = r[COEF_W-1:0];
            endcase
          end
        endcase
      end
      program_coefs(w);
      gap_mode   = phase % 3;
      stall_mode = (phase + 1) % 3;
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        // Hold the sender until the pipe has emptied
        if (phase % 2 == 1 && n == PHASE_FRAMES / 2 && filtered_q.size() != 0) begin
          in_valid <= 1'b0;
          while (filtered_q.size() != 0) @(posedge clk);
        end
        for (int c = 0; c < IO_CHANNELS; c++) smp[c] = pick_sample(smp[c]);
        send_frame(smp, 1'b0, none);
      end
    end

    // Drain and let any stray result show up
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Filtered %0d four-channel frames under %0d weight settings (%0d register writes).",
             frames_sent, coef_settings, coef_writes);
    $display("Compared %0d results; %0d mismatching fields.", results_seen, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
